>>> rtl/core/tcsa_pkg.sv
// Shared types, register codes and fixed-point helpers for the tone and saturation pipeline.
package tcsa_pkg;

   localparam logic [2:0] CSR_CONTRAST    = 3'd0;
   localparam logic [2:0] CSR_BRIGHTNESS  = 3'd1;
   localparam logic [2:0] CSR_TEMPERATURE = 3'd2;
   localparam logic [2:0] CSR_TINT        = 3'd3;
   localparam logic [2:0] CSR_ZONES       = 3'd4;
   localparam logic [2:0] CSR_SATURATION  = 3'd5;
   localparam logic [2:0] CSR_VIBRANCE    = 3'd6;

   // ceil(2^37 / 100)
   localparam logic [30:0] Recip100 = 31'd1374389535;

   typedef struct packed {
      logic signed [18:0] gain;
      logic signed [18:0] offset;
      logic signed [18:0] warm;
      logic signed [18:0] grn;
      logic [2:0][18:0]   zone_a;
   } tone_cfg_type;

   typedef struct packed {
      logic               en;
      logic signed [18:0] sat_term;
      logic signed [18:0] vib_term;
   } sat_cfg_type;

   // floor(n / 100) for n below 2^24
   function automatic logic [17:0] div100(input logic [23:0] n);
      logic [54:0] p;
      p = 55'(n) * 55'(Recip100);
      return p[54:37];
   endfunction

   // round(x * 2^sh / 100), ties away from zero
   function automatic logic signed [18:0] pct_q(input logic signed [9:0] x,
                                                input logic [4:0] sh);
      logic [8:0]  mag;
      logic [23:0] n;
      logic [17:0] q;
      mag = x[9] ? 9'(-x) : x[8:0];
      n   = (24'(mag) << sh) + 24'd50;
      q   = div100(n);
      return x[9] ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   // round(n / 2^16), ties away from zero
   function automatic logic signed [47:0] rq16(input logic signed [47:0] n);
      logic signed [47:0] t;
      t = n + (n[47] ? 48'sd32767 : 48'sd32768);
      return t >>> 16;
   endfunction

endpackage

>>> rtl/core/tcsa_tone.sv
// Tone curve pipeline: contrast, offsets and three zone steps per color channel.
module tcsa_tone (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [31:0]            pixel_in,
   input  tcsa_pkg::tone_cfg_type cfg,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [2:0][7:0]        out_chan,
   output logic [7:0]             out_alpha
);
   localparam int Stages = 5;

   logic [Stages-1:0]      vld_ff;
   logic [Stages-1:0]      adv;
   logic [Stages-1:0][7:0] alpha_ff;

   logic signed [36:0] prod_in [3];
   logic signed [36:0] prod_ff [3];
   logic signed [23:0] tone_cur [3][3];
   logic signed [23:0] tone_ff [3][3];
   logic signed [36:0] pz_in [3][3];
   logic signed [36:0] pz_ff [3][3];
   logic [2:0][7:0]    chan_in;
   logic [2:0][7:0]    chan_ff;

   function automatic logic [16:0] zone_w(input logic signed [23:0] t, input logic [1:0] z);
      logic signed [24:0] dv;
      logic [24:0]        ad;
      dv = 25'(t) - $signed({8'b0, z, 15'b0});
      ad = dv[24] ? 25'(-dv) : 25'(dv);
      if (ad >= 25'd32768) begin
         return 17'd0;
      end
      return 17'd65536 - {ad[15:0], 1'b0};
   endfunction

   function automatic logic signed [47:0] rq16_w(input logic signed [36:0] n);
      return tcsa_pkg::rq16(48'(n));
   endfunction

   always_comb begin
      adv[Stages-1] = !vld_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end
   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < Stages; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_comb begin
      logic [7:0]         i;
      logic [16:0]        t0;
      logic signed [17:0] d;
      logic signed [23:0] chan_off;
      logic signed [23:0] tfin;
      logic signed [31:0] v;
      for (int c = 0; c < 3; c++) begin
         i  = pixel_in[8*c +: 8];
         t0 = {1'b0, i, i} + 17'(i[7]);
         d  = $signed({1'b0, t0}) - 18'sd32768;
         prod_in[c] = 37'(d) * 37'(cfg.gain);

         chan_off = (c == 0) ? -24'(cfg.warm) : ((c == 1) ? 24'(cfg.grn) : 24'(cfg.warm));
         tone_cur[0][c] = 24'sd32768 + 24'(rq16_w(prod_ff[c])) + 24'(cfg.offset) + chan_off;
         for (int z = 1; z < 3; z++) begin
            tone_cur[z][c] = tone_ff[z-1][c] + 24'(rq16_w(pz_ff[z-1][c]));
         end
         for (int z = 0; z < 3; z++) begin
            pz_in[z][c] = 37'($signed(cfg.zone_a[z])) *
                          37'($signed({1'b0, zone_w(tone_cur[z][c], 2'(z))}));
         end

         tfin = tone_ff[2][c] + 24'(rq16_w(pz_ff[2][c]));
         v    = (32'(tfin) <<< 8) - 32'(tfin) + 32'sd32768;
         if (v[31]) begin
            chan_in[c] = 8'd0;
         end else if (|v[30:24]) begin
            chan_in[c] = 8'd255;
         end else begin
            chan_in[c] = v[23:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         alpha_ff[0] <= pixel_in[31:24];
         for (int c = 0; c < 3; c++) prod_ff[c] <= prod_in[c];
      end
      for (int z = 0; z < 3; z++) begin
         if (adv[z+1]) begin
            alpha_ff[z+1] <= alpha_ff[z];
            for (int c = 0; c < 3; c++) begin
               tone_ff[z][c] <= tone_cur[z][c];
               pz_ff[z][c]   <= pz_in[z][c];
            end
         end
      end
      if (adv[4]) begin
         alpha_ff[4] <= alpha_ff[3];
         chan_ff     <= chan_in;
      end
   end

   assign out_valid = vld_ff[Stages-1];
   assign out_chan  = chan_ff;
   assign out_alpha = alpha_ff[Stages-1];

endmodule

>>> rtl/core/tcsa_chroma.sv
// Luma grey, channel max/min and a 4-bit-per-stage chroma divider.
module tcsa_chroma (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [2:0][7:0] in_chan,
   input  logic [7:0]      in_alpha,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [2:0][7:0] out_chan,
   output logic [7:0]      out_alpha,
   output logic [23:0]     out_grey,
   output logic [16:0]     out_chroma
);
   localparam int Stages = 5;

   logic [Stages-1:0]            vld_ff;
   logic [Stages-1:0]            adv;
   logic [Stages-1:0][7:0]       alpha_ff;
   logic [Stages-1:0][2:0][7:0]  chan_ff;
   logic [Stages-1:0][23:0]      grey_ff;
   logic [Stages-1:0][7:0]       hi_ff;
   logic [Stages-1:0]            hi_zero_ff;
   logic [Stages-1:0]            lo_zero_ff;
   logic [Stages-1:0][8:0]       rem_ff;
   logic [Stages-1:0][15:0]      q_ff;

   logic [23:0]            grey_in;
   logic [7:0]             hi_in;
   logic [7:0]             lo_in;
   logic [Stages-1:0][8:0] rem_in;
   logic [Stages-1:0][15:0] q_in;

   always_comb begin
      adv[Stages-1] = !vld_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < Stages; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_comb begin
      logic [8:0] r;
      grey_in = 24'(in_chan[0]) * 24'd7471 + 24'(in_chan[1]) * 24'd38470 +
                24'(in_chan[2]) * 24'd19595;
      hi_in = in_chan[0];
      lo_in = in_chan[0];
      for (int c = 1; c < 3; c++) begin
         if (in_chan[c] > hi_in) hi_in = in_chan[c];
         if (in_chan[c] < lo_in) lo_in = in_chan[c];
      end
      rem_in[0] = {1'b0, hi_in - lo_in};
      q_in[0]   = '0;
      for (int k = 1; k < Stages; k++) begin
         r       = rem_ff[k-1];
         q_in[k] = q_ff[k-1];
         for (int j = 0; j < 4; j++) begin
            r       = {r[7:0], 1'b0};
            q_in[k] = {q_in[k][14:0], 1'b0};
            if (r >= {1'b0, hi_ff[k-1]}) begin
               r          = r - {1'b0, hi_ff[k-1]};
               q_in[k][0] = 1'b1;
            end
         end
         rem_in[k] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         alpha_ff[0]   <= in_alpha;
         chan_ff[0]    <= in_chan;
         grey_ff[0]    <= grey_in;
         hi_ff[0]      <= hi_in;
         hi_zero_ff[0] <= (hi_in == 8'd0);
         lo_zero_ff[0] <= (lo_in == 8'd0);
         rem_ff[0]     <= rem_in[0];
         q_ff[0]       <= q_in[0];
      end
      for (int k = 1; k < Stages; k++) begin
         if (adv[k]) begin
            alpha_ff[k]   <= alpha_ff[k-1];
            chan_ff[k]    <= chan_ff[k-1];
            grey_ff[k]    <= grey_ff[k-1];
            hi_ff[k]      <= hi_ff[k-1];
            hi_zero_ff[k] <= hi_zero_ff[k-1];
            lo_zero_ff[k] <= lo_zero_ff[k-1];
            rem_ff[k]     <= rem_in[k];
            q_ff[k]       <= q_in[k];
         end
      end
   end

   // black gives zero chroma; a zero minimum gives full chroma
   always_comb begin
      if (hi_zero_ff[Stages-1]) begin
         out_chroma = 17'd0;
      end else if (lo_zero_ff[Stages-1]) begin
         out_chroma = 17'd65536;
      end else begin
         out_chroma = {1'b0, q_ff[Stages-1]};
      end
   end

   assign out_valid = vld_ff[Stages-1];
   assign out_chan  = chan_ff[Stages-1];
   assign out_alpha = alpha_ff[Stages-1];
   assign out_grey  = grey_ff[Stages-1];

endmodule

>>> rtl/core/tcsa_push.sv
// Saturation and vibrance push away from grey, with the output register.
module tcsa_push (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [2:0][7:0]       in_chan,
   input  logic [7:0]            in_alpha,
   input  logic [23:0]           in_grey,
   input  logic [16:0]           in_chroma,
   input  tcsa_pkg::sat_cfg_type cfg,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_pixel_out
);
   localparam int Stages = 3;

   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] adv;

   logic [7:0]         alpha0_ff;
   logic [7:0]         alpha1_ff;
   logic [2:0][7:0]    chan0_ff;
   logic [2:0][7:0]    chan1_ff;
   logic [23:0]        grey0_ff;
   logic [23:0]        grey1_ff;
   logic signed [36:0] vp_in;
   logic signed [36:0] vp_ff;
   logic signed [25:0] diff_in [3];
   logic signed [25:0] diff_ff [3];
   logic signed [45:0] m_in [3];
   logic signed [45:0] m_ff [3];
   logic signed [19:0] scale;
   logic [2:0][7:0]    chan_in;
   logic [31:0]        pixel_ff;

   always_comb begin
      adv[Stages-1] = !vld_ff[Stages-1] || rsp_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < Stages; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_comb begin
      logic [16:0]        cterm;
      logic signed [47:0] v;
      cterm = 17'd65536 - in_chroma;
      vp_in = 37'(cfg.vib_term) * 37'($signed({1'b0, cterm}));
      for (int c = 0; c < 3; c++) begin
         diff_in[c] = $signed({2'b0, in_chan[c], 16'b0}) - $signed({2'b0, in_grey});
      end

      scale = 20'sd65536 + 20'(cfg.sat_term) + 20'(tcsa_pkg::rq16(48'(vp_ff)));
      for (int c = 0; c < 3; c++) begin
         m_in[c] = 46'(diff_ff[c]) * 46'(scale);
      end

      for (int c = 0; c < 3; c++) begin
         v = $signed({8'b0, grey1_ff, 16'b0}) + 48'(m_ff[c]) + 48'sd2147483648;
         if (!cfg.en) begin
            chan_in[c] = chan1_ff[c];
         end else if (v[47]) begin
            chan_in[c] = 8'd0;
         end else if (|v[46:40]) begin
            chan_in[c] = 8'd255;
         end else begin
            chan_in[c] = v[39:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         alpha0_ff <= in_alpha;
         chan0_ff  <= in_chan;
         grey0_ff  <= in_grey;
         vp_ff     <= vp_in;
         for (int c = 0; c < 3; c++) diff_ff[c] <= diff_in[c];
      end
      if (adv[1]) begin
         alpha1_ff <= alpha0_ff;
         chan1_ff  <= chan0_ff;
         grey1_ff  <= grey0_ff;
         for (int c = 0; c < 3; c++) m_ff[c] <= m_in[c];
      end
      if (adv[2]) begin
         pixel_ff <= {alpha1_ff, chan_in[2], chan_in[1], chan_in[0]};
      end
   end

   assign rsp_valid     = vld_ff[Stages-1];
   assign rsp_pixel_out = pixel_ff;

endmodule

>>> rtl/core/tone_curve_saturation_adjust.sv
// Top level: configuration registers and the tone, chroma and push pipeline.
// Takes one BGRA pixel per clock while the output side keeps up and passes it through
// five tone-curve stages, a grey/max/min stage plus four chroma divider stages of
// four quotient bits each, and three saturation stages ending in the output register.
// Every stage holds while the one after it is full and cannot move on, so a stall on
// the result side backs up stage by stage and bubbles are squeezed out. Alpha passes
// unchanged. Register writes are to be made only once the pipeline has drained, so
// that they take effect from the next request; the block itself does not enforce it.
module tone_curve_saturation_adjust (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_out,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   tcsa_pkg::tone_cfg_type tone_cfg_ff;
   tcsa_pkg::sat_cfg_type  sat_cfg;
   logic                   sat_nz_ff;
   logic                   vib_nz_ff;
   logic signed [18:0]     sat_term_ff;
   logic signed [18:0]     vib_term_ff;

   logic signed [9:0] wval;
   assign wval = $signed({{2{csr_wdata[7]}}, csr_wdata[7:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_cfg_ff.gain   <= 19'sd65536;
         tone_cfg_ff.offset <= '0;
         tone_cfg_ff.warm   <= '0;
         tone_cfg_ff.grn    <= '0;
         tone_cfg_ff.zone_a <= '0;
         sat_nz_ff          <= 1'b0;
         vib_nz_ff          <= 1'b0;
         sat_term_ff        <= '0;
         vib_term_ff        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tcsa_pkg::CSR_CONTRAST:
               tone_cfg_ff.gain <= 19'sd65536 + tcsa_pkg::pct_q(wval, 5'd16);
            tcsa_pkg::CSR_BRIGHTNESS:
               tone_cfg_ff.offset <= tcsa_pkg::pct_q(wval, 5'd15);
            tcsa_pkg::CSR_TEMPERATURE:
               tone_cfg_ff.warm <= tcsa_pkg::pct_q(wval, 5'd14);
            tcsa_pkg::CSR_TINT:
               tone_cfg_ff.grn <= tcsa_pkg::pct_q(wval, 5'd14);
            tcsa_pkg::CSR_ZONES: begin
               for (int z = 0; z < 3; z++) begin
                  tone_cfg_ff.zone_a[z] <= tcsa_pkg::pct_q(
                     $signed({2'b00, csr_wdata[8*z +: 8]}) - 10'sd100, 5'd15);
               end
            end
            tcsa_pkg::CSR_SATURATION: begin
               sat_nz_ff   <= (csr_wdata[7:0] != 8'd0);
               sat_term_ff <= tcsa_pkg::pct_q(wval, 5'd16);
            end
            tcsa_pkg::CSR_VIBRANCE: begin
               vib_nz_ff   <= (csr_wdata[7:0] != 8'd0);
               vib_term_ff <= tcsa_pkg::pct_q(wval, 5'd16);
            end
            default: ;
         endcase
      end
   end

   assign sat_cfg.en       = sat_nz_ff || vib_nz_ff;
   assign sat_cfg.sat_term = sat_term_ff;
   assign sat_cfg.vib_term = vib_term_ff;

   logic            tone_valid;
   logic            tone_ready;
   logic [2:0][7:0] tone_chan;
   logic [7:0]      tone_alpha;
   logic            chr_valid;
   logic            chr_ready;
   logic [2:0][7:0] chr_chan;
   logic [7:0]      chr_alpha;
   logic [23:0]     chr_grey;
   logic [16:0]     chr_chroma;

   tcsa_tone u_tone (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .pixel_in  (req_pixel_in),
      .cfg       (tone_cfg_ff),
      .out_valid (tone_valid),
      .out_ready (tone_ready),
      .out_chan  (tone_chan),
      .out_alpha (tone_alpha)
   );

   tcsa_chroma u_chroma (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (tone_valid),
      .in_ready   (tone_ready),
      .in_chan    (tone_chan),
      .in_alpha   (tone_alpha),
      .out_valid  (chr_valid),
      .out_ready  (chr_ready),
      .out_chan   (chr_chan),
      .out_alpha  (chr_alpha),
      .out_grey   (chr_grey),
      .out_chroma (chr_chroma)
   );

   tcsa_push u_push (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (chr_valid),
      .in_ready      (chr_ready),
      .in_chan       (chr_chan),
      .in_alpha      (chr_alpha),
      .in_grey       (chr_grey),
      .in_chroma     (chr_chroma),
      .cfg           (sat_cfg),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out)
   );

endmodule

>>> verif/tone_curve_saturation_adjust_checker.sv
// Checker: predicts each adjusted pixel from the observed register writes and compares.
module tone_curve_saturation_adjust_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_pixel_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_pixel_out,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint QONE = 65536;
   localparam longint QHALF = 32768;

   logic [7:0]  r_contrast, r_bright, r_temp, r_tint, r_sat, r_vib;
   logic [23:0] r_zones;
   logic [31:0] pixel_q[$];

   assign pending = pixel_q.size();

   function automatic longint div_round(longint n, longint d);
      if (n < 0) return -((-n + d / 2) / d);
      return (n + d / 2) / d;
   endfunction

   function automatic longint sx8(logic [7:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint clip8(longint v);
      return v < 0 ? 0 : (v > 255 ? 255 : v);
   endfunction

   function automatic longint bump_weight(longint tone, longint centre);
      longint d;
      d = tone - centre;
      if (d < 0) d = -d;
      return d >= QHALF ? 0 : QONE - 2 * d;
   endfunction

   function automatic longint curve(longint i, longint chan_off);
      longint g, off, t0, tone, amt, a, v;
      g = QONE + div_round(sx8(r_contrast) * QONE, 100);
      off = div_round(sx8(r_bright) * QONE, 200);
      t0 = (i * QONE + 127) / 255;
      tone = QHALF + div_round((t0 - QHALF) * g, QONE) + off + chan_off;
      for (int k = 0; k < 3; k++) begin
         amt = longint'(r_zones[8*k +: 8]) - 100;
         a = div_round(amt * QONE, 200);
         tone += div_round(a * bump_weight(tone, k * QHALF), QONE);
      end
      v = tone * 255 + QHALF;
      if (v < 0) return 0;
      return clip8(v / QONE);
   endfunction

   function automatic longint push_away(longint ch, longint grey, longint s);
      longint v;
      v = grey * QONE + (ch * QONE - grey) * s + (longint'(1) << 31);
      if (v < 0) return 0;
      return clip8(v / (longint'(1) << 32));
   endfunction

   function automatic logic [31:0] adjusted_pixel(logic [31:0] p);
      longint warm, grn, b, g, r, grey, hi, lo, c, s;
      warm = div_round(sx8(r_temp) * QONE, 400);
      grn = div_round(sx8(r_tint) * QONE, 400);
      b = curve(p[7:0], -warm);
      g = curve(p[15:8], grn);
      r = curve(p[23:16], warm);
      if (r_sat != 0 || r_vib != 0) begin
         grey = 7471 * b + 38470 * g + 19595 * r;
         hi = b; lo = b; c = 0;
         if (g > hi) hi = g;
         if (r > hi) hi = r;
         if (g < lo) lo = g;
         if (r < lo) lo = r;
         if (hi > 0) c = ((hi - lo) * QONE) / hi;
         s = QONE + div_round(sx8(r_sat) * QONE, 100)
             + div_round(div_round(sx8(r_vib) * QONE, 100) * (QONE - c), QONE);
         b = push_away(b, grey, s);
         g = push_away(g, grey, s);
         r = push_away(r, grey, s);
      end
      return {p[31:24], r[7:0], g[7:0], b[7:0]};
   endfunction

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         r_contrast <= '0; r_bright <= '0; r_temp <= '0; r_tint <= '0;
         r_zones <= 24'h646464; r_sat <= '0; r_vib <= '0;
         fail_count <= 0;
         pixel_q.delete();
      end else begin
         if (req_valid && req_ready)
            pixel_q.insert(pixel_q.size(), adjusted_pixel(req_pixel_in));
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_pixel_out);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_q.pop_front();
               if (want !== rsp_pixel_out) begin
                  $display("%0t: pixel_out expected %h actual %h", $time, want,
                           rsp_pixel_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               tcsa_pkg::CSR_CONTRAST:    r_contrast <= csr_wdata[7:0];
               tcsa_pkg::CSR_BRIGHTNESS:  r_bright <= csr_wdata[7:0];
               tcsa_pkg::CSR_TEMPERATURE: r_temp <= csr_wdata[7:0];
               tcsa_pkg::CSR_TINT:        r_tint <= csr_wdata[7:0];
               tcsa_pkg::CSR_ZONES:       r_zones <= csr_wdata;
               tcsa_pkg::CSR_SATURATION:  r_sat <= csr_wdata[7:0];
               tcsa_pkg::CSR_VIBRANCE:    r_vib <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end
endmodule

>>> verif/tone_curve_saturation_adjust_tb.sv
// Testbench top: drives pixel requests and register settings, gives the verdict.
module tone_curve_saturation_adjust_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_pixel_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_pixel_out;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;
   int          fail_count, pending;
   int          send_idle_pct = 0, recv_stall_pct = 0;
   bit          hold_rsp = 1'b0;
   int          quiet_cycles = 0;

   always #5 clock = ~clock;

   tone_curve_saturation_adjust i_dut (.*);
   tone_curve_saturation_adjust_checker i_chk (.*);

   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_pixel(input logic [31:0] p);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_pct();
      case ($urandom_range(5))
         0: return 8'sd100;
         1: return -8'sd100;
         2: return 8'd0;
         3: return 8'($urandom());
         default: return 8'($signed($urandom_range(200)) - 100);
      endcase
   endfunction

   function automatic logic [31:0] pick_pixel();
      logic [31:0] p;
      p = $urandom();
      case ($urandom_range(7))
         0: p[23:0] = 24'h000000;
         1: p[23:0] = 24'hffffff;
         2: p[23:0] = {3{p[7:0]}};
         default: ;
      endcase
      return p;
   endfunction

   task automatic random_setting;
      write_reg(tcsa_pkg::CSR_CONTRAST, 24'(pick_pct()));
      write_reg(tcsa_pkg::CSR_BRIGHTNESS, 24'(pick_pct()));
      write_reg(tcsa_pkg::CSR_TEMPERATURE, 24'(pick_pct()));
      write_reg(tcsa_pkg::CSR_TINT, 24'(pick_pct()));
      write_reg(tcsa_pkg::CSR_ZONES, ($urandom_range(3) == 0) ? 24'($urandom())
                : {8'($urandom_range(200)), 8'($urandom_range(200)),
                   8'($urandom_range(200))});
      write_reg(tcsa_pkg::CSR_SATURATION,
                ($urandom_range(3) == 0) ? 24'd0 : 24'(pick_pct()));
      write_reg(tcsa_pkg::CSR_VIBRANCE,
                ($urandom_range(3) == 0) ? 24'd0 : 24'(pick_pct()));
      write_reg(CSR_UNUSED, 24'($urandom()));
   endtask

   initial begin
      logic [31:0] directed[$];
      directed = '{32'h00000000, 32'hffffffff, 32'hff000000, 32'h00ffffff,
                   32'h80808080, 32'h12ff0000, 32'h3400ff00, 32'h560000ff,
                   32'h7f7f7f7f, 32'h01010101, 32'hfefefefe, 32'ha5c03a10};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_pixel(directed[i]);
      drain();
      // two sets of extreme settings with saturation push and zone bytes past 200
      write_reg(tcsa_pkg::CSR_CONTRAST, 24'h64);
      write_reg(tcsa_pkg::CSR_BRIGHTNESS, 24'h9c);
      write_reg(tcsa_pkg::CSR_TEMPERATURE, 24'h64);
      write_reg(tcsa_pkg::CSR_TINT, 24'h9c);
      write_reg(tcsa_pkg::CSR_ZONES, 24'hffc800);
      write_reg(tcsa_pkg::CSR_SATURATION, 24'h64);
      write_reg(tcsa_pkg::CSR_VIBRANCE, 24'h9c);
      foreach (directed[i]) send_pixel(directed[i]);
      drain();
      write_reg(tcsa_pkg::CSR_CONTRAST, 24'h80);
      write_reg(tcsa_pkg::CSR_ZONES, 24'h00ffc8);
      write_reg(tcsa_pkg::CSR_SATURATION, 24'h9c);
      write_reg(tcsa_pkg::CSR_VIBRANCE, 24'h7f);
      foreach (directed[i]) send_pixel(directed[i]);
      drain();

      for (int ph = 0; ph < 16; ph++) begin
         random_setting();
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         if (ph == 5) begin
            hold_rsp = 1'b1;
            fork
               begin repeat (200) @(posedge clock); hold_rsp = 1'b0; end
               repeat (100) send_pixel(pick_pixel());
            join
         end else begin
            repeat (100) send_pixel(pick_pixel());
         end
         drain();
      end

      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

>>> tone_curve_saturation_adjust.f
rtl/core/tcsa_pkg.sv
rtl/core/tcsa_tone.sv
rtl/core/tcsa_chroma.sv
rtl/core/tcsa_push.sv
rtl/core/tone_curve_saturation_adjust.sv
verif/tone_curve_saturation_adjust_checker.sv
verif/tone_curve_saturation_adjust_tb.sv
